### design/c2c_pkg.sv
package c2c_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_COLUMNS = 256;
  localparam int ROW_BITS    = 16;
  localparam int ENTRY_AW    = 10;
  localparam int CNT_W       = 11;
  localparam int COL_AW      = 9;
  localparam int COL_W       = 8;
  localparam int VAL_W       = 64;
  localparam int NCOL_W      = 9;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_COL  = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_READ = 1'b1;

  typedef struct packed {
    logic                action;
    logic [COL_W-1:0]    col_index;
    logic [15:0]         row_index;
    logic [VAL_W-1:0]    element;
    logic                last;
    logic [CNT_W-1:0]    read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [CNT_W-1:0]    entry_total;
    logic [CNT_W-1:0]    col_start_value;
    logic [15:0]         sorted_row;
    logic [VAL_W-1:0]    sorted_element;
  } out_item_t;

endpackage

### design/c2c_ram.sv
module c2c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/coo_to_csc_converter_top.sv
// Sparse matrix converter from coordinate triples to compressed sparse column form.
// Input transactions arrive on in_valid/in_stall/in_data; a load transaction stores
// one (column, row, value) triple, a read transaction fetches the column start and
// the sorted row and value at read_index. Every input transaction yields exactly one
// output transaction on out_valid/out_stall/out_data. The cfg_ channel writes the
// column count and is always ready; write it only while the block is idle.
// A load's answer is registered in the cycle after it is accepted; a read passes
// through ST_READ first. A load flagged last then starts the conversion, run by a
// small sequencer on simple dual-port RAMs: it clears the column counts, counts the
// stored entries per column, forms the prefix sum and scatters each entry.
// The block takes no new transaction while converting, while a read is in ST_READ
// or while a result is held; the held result blocks the input until it leaves.
// When the receiver stalls, the result stays in the output register unchanged.
// Synchronous reset empties the store, zeroes the entry count, sets the column count
// to 256 and makes reads return zero column starts; RAM contents are not cleared.
module coo_to_csc_converter_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  c2c_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output c2c_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [c2c_pkg::NCOL_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CLR, ST_CNT_A, ST_CNT_B, ST_CNT_C,
    ST_PRE_A, ST_PRE_B, ST_SC_A, ST_SC_B, ST_SC_C
  } state_t;

  localparam int LD_W = c2c_pkg::COL_W + c2c_pkg::ROW_BITS + c2c_pkg::VAL_W;
  localparam int SR_W = c2c_pkg::ROW_BITS + c2c_pkg::VAL_W;

  state_t state_r;
  logic [c2c_pkg::NCOL_W-1:0] num_columns_r;
  logic [c2c_pkg::CNT_W-1:0]  entry_count_r;
  logic                       converted_r;
  logic [c2c_pkg::CNT_W-1:0]  idx_r;
  logic [c2c_pkg::CNT_W-1:0]  acc_r;
  logic [c2c_pkg::CNT_W-1:0]  ridx_r;
  logic                       out_valid_r;
  c2c_pkg::out_item_t         out_data_r;

  // RAM ports.
  logic                        ld_we;
  logic [c2c_pkg::ENTRY_AW-1:0] ld_waddr;
  logic [LD_W-1:0]             ld_wdata, ld_rdata;
  logic                        cs_we;
  logic [c2c_pkg::COL_AW-1:0]  cs_waddr, cs_raddr;
  logic [c2c_pkg::CNT_W-1:0]   cs_wdata, cs_rdata;
  logic                        fp_we;
  logic [c2c_pkg::COL_AW-1:0]  fp_waddr, fp_raddr;
  logic [c2c_pkg::CNT_W-1:0]   fp_wdata, fp_rdata;
  logic                        sr_we;
  logic [SR_W-1:0]             sr_rdata;

  logic                        accept;
  logic                        is_load;
  logic [c2c_pkg::CNT_W-1:0]   base_count;
  logic                        col_bad;
  logic                        store_full;
  logic                        load_ok;
  logic [c2c_pkg::COL_W-1:0]   ld_col;
  logic [c2c_pkg::COL_AW-1:0]  ld_col_next;
  logic [c2c_pkg::CNT_W-1:0]   acc_sum;

  assign cfg_ready = 1'b1;
  assign in_stall  = !((state_r == ST_IDLE) && !out_valid_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept  = in_valid && !in_stall;
  assign is_load = (in_data.action == c2c_pkg::ACTION_LOAD);

  // A load after a finished conversion starts a new matrix from zero entries.
  assign base_count = converted_r ? '0 : entry_count_r;
  assign col_bad    = {1'b0, in_data.col_index} >= num_columns_r;
  assign store_full = base_count == c2c_pkg::CNT_W'(c2c_pkg::MAX_ENTRIES);
  assign load_ok    = accept && is_load && !col_bad && !store_full;

  assign ld_col      = ld_rdata[LD_W-1 -: c2c_pkg::COL_W];
  assign ld_col_next = c2c_pkg::COL_AW'({1'b0, ld_col} + 9'd1);
  assign acc_sum     = acc_r + cs_rdata;

  assign ld_we    = load_ok;
  assign ld_waddr = base_count[c2c_pkg::ENTRY_AW-1:0];
  assign ld_wdata = {in_data.col_index, in_data.row_index[c2c_pkg::ROW_BITS-1:0],
                     in_data.element};

  always_comb begin
    cs_we    = 1'b0;
    cs_waddr = idx_r[c2c_pkg::COL_AW-1:0];
    cs_wdata = '0;
    fp_we    = 1'b0;
    fp_waddr = idx_r[c2c_pkg::COL_AW-1:0];
    fp_wdata = '0;
    fp_raddr = {1'b0, ld_col};
    sr_we    = 1'b0;
    case (state_r)
      ST_IDLE:  cs_raddr = in_data.read_index[c2c_pkg::COL_AW-1:0];
      ST_PRE_A,
      ST_PRE_B: cs_raddr = idx_r[c2c_pkg::COL_AW-1:0];
      default:  cs_raddr = ld_col_next;
    endcase
    case (state_r)
      ST_CLR: begin
        cs_we = 1'b1;
        fp_we = 1'b1;
      end
      ST_CNT_C: begin
        cs_we    = 1'b1;
        cs_waddr = ld_col_next;
        cs_wdata = cs_rdata + 11'd1;
      end
      ST_PRE_B: begin
        cs_we    = 1'b1;
        cs_wdata = acc_sum;
        fp_we    = 1'b1;
        fp_wdata = acc_sum;
      end
      ST_SC_C: begin
        sr_we    = 1'b1;
        fp_we    = 1'b1;
        fp_waddr = {1'b0, ld_col};
        fp_wdata = fp_rdata + 11'd1;
      end
      default: ;
    endcase
  end

  c2c_ram #(.WIDTH(LD_W), .DEPTH(c2c_pkg::MAX_ENTRIES)) u_loaded (
    .clk(clk), .we(ld_we), .waddr(ld_waddr), .wdata(ld_wdata),
    .raddr(idx_r[c2c_pkg::ENTRY_AW-1:0]), .rdata(ld_rdata)
  );

  c2c_ram #(.WIDTH(c2c_pkg::CNT_W), .DEPTH(c2c_pkg::MAX_COLUMNS + 1)) u_starts (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  c2c_ram #(.WIDTH(c2c_pkg::CNT_W), .DEPTH(c2c_pkg::MAX_COLUMNS + 1)) u_fill (
    .clk(clk), .we(fp_we), .waddr(fp_waddr), .wdata(fp_wdata),
    .raddr(fp_raddr), .rdata(fp_rdata)
  );

  c2c_ram #(.WIDTH(SR_W), .DEPTH(c2c_pkg::MAX_ENTRIES)) u_sorted (
    .clk(clk), .we(sr_we), .waddr(fp_rdata[c2c_pkg::ENTRY_AW-1:0]),
    .wdata(ld_rdata[SR_W-1:0]),
    .raddr(in_data.read_index[c2c_pkg::ENTRY_AW-1:0]), .rdata(sr_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_columns_r <= c2c_pkg::NCOL_W'(c2c_pkg::MAX_COLUMNS);
      entry_count_r <= '0;
      converted_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      idx_r         <= '0;
      acc_r         <= '0;
      ridx_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_columns_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && is_load) begin
            converted_r   <= 1'b0;
            entry_count_r <= load_ok ? base_count + 11'd1 : base_count;
            out_valid_r   <= 1'b1;
            out_data_r.status <= col_bad ? c2c_pkg::STATUS_BAD_COL :
                                 store_full ? c2c_pkg::STATUS_FULL : c2c_pkg::STATUS_OK;
            out_data_r.entry_total     <= load_ok ? base_count + 11'd1 : base_count;
            out_data_r.col_start_value <= '0;
            out_data_r.sorted_row      <= '0;
            out_data_r.sorted_element  <= '0;
            if (in_data.last) begin
              idx_r   <= '0;
              state_r <= ST_CLR;
            end
          end else if (accept) begin
            ridx_r  <= in_data.read_index;
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          out_valid_r <= 1'b1;
          out_data_r.status      <= c2c_pkg::STATUS_OK;
          out_data_r.entry_total <= entry_count_r;
          out_data_r.col_start_value <=
            (converted_r && ridx_r <= c2c_pkg::CNT_W'(c2c_pkg::MAX_COLUMNS)) ?
            cs_rdata : '0;
          if (converted_r && ridx_r < entry_count_r) begin
            out_data_r.sorted_row     <= sr_rdata[SR_W-1 -: c2c_pkg::ROW_BITS];
            out_data_r.sorted_element <= sr_rdata[c2c_pkg::VAL_W-1:0];
          end else begin
            out_data_r.sorted_row     <= '0;
            out_data_r.sorted_element <= '0;
          end
          state_r <= ST_IDLE;
        end
        ST_CLR: begin
          if (idx_r == c2c_pkg::CNT_W'(c2c_pkg::MAX_COLUMNS)) begin
            if (entry_count_r == '0) begin
              idx_r   <= 11'd1;
              acc_r   <= '0;
              state_r <= ST_PRE_A;
            end else begin
              idx_r   <= '0;
              state_r <= ST_CNT_A;
            end
          end else begin
            idx_r <= idx_r + 11'd1;
          end
        end
        ST_CNT_A: state_r <= ST_CNT_B;
        ST_CNT_B: state_r <= ST_CNT_C;
        ST_CNT_C: begin
          if (idx_r + 11'd1 == entry_count_r) begin
            idx_r   <= 11'd1;
            acc_r   <= '0;
            state_r <= ST_PRE_A;
          end else begin
            idx_r   <= idx_r + 11'd1;
            state_r <= ST_CNT_A;
          end
        end
        ST_PRE_A: state_r <= ST_PRE_B;
        ST_PRE_B: begin
          acc_r <= acc_sum;
          if (idx_r == c2c_pkg::CNT_W'(c2c_pkg::MAX_COLUMNS)) begin
            idx_r <= '0;
            if (entry_count_r == '0) begin
              converted_r <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              state_r <= ST_SC_A;
            end
          end else begin
            idx_r   <= idx_r + 11'd1;
            state_r <= ST_PRE_A;
          end
        end
        ST_SC_A: state_r <= ST_SC_B;
        ST_SC_B: state_r <= ST_SC_C;
        ST_SC_C: begin
          if (idx_r + 11'd1 == entry_count_r) begin
            converted_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            idx_r   <= idx_r + 11'd1;
            state_r <= ST_SC_A;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
